// File: hw/rtl/fsgs_pkg.sv
package fsgs_pkg;

	localparam int GRID_ROWS_DEF = 64;
	localparam int GRID_COLS_DEF = 64;

	localparam int KIND_W  = 2;
	localparam int COORD_W = 6;
	localparam int CELL_W  = 16;
	localparam int COUNT_W = 24;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam logic [CELL_W-1:0]  SEED_RESET = 16'd44257;
	localparam logic [CELL_W-1:0]  LFSR_TAPS  = 16'hB400;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 24'hFFFFFF;
	localparam logic [CELL_W-1:0]  COLOUR_MAX = 16'hFFFF;

	typedef enum logic [KIND_W-1:0] {
		KIND_PLACE = 2'd0,
		KIND_STEP  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	localparam logic REG_RNG_SEED = 1'b0;

	typedef enum logic [3:0] {
		ST_INIT_CLR,
		ST_IDLE,
		ST_PLACE,
		ST_CLEAR,
		ST_SW_RD,
		ST_SW_CHK,
		ST_SW_DIAG,
		ST_SW_WR0,
		ST_SW_WR1,
		ST_FETCH,
		ST_LOAD
	} state_t;

	function automatic logic [CELL_W-1:0] lfsr_next(input logic [CELL_W-1:0] v);
		logic [CELL_W-1:0] o;
		o = v >> 1;
		if (v[0]) begin
			o = o ^ LFSR_TAPS;
		end
		return o;
	endfunction

endpackage

// File: hw/rtl/fsgs_if.sv
interface fsgs_req_if;
	import fsgs_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [COORD_W-1:0] col;
	logic [COORD_W-1:0] row;

	modport source (output valid, kind, col, row, input ready);
	modport sink (input valid, kind, col, row, output ready);
endinterface

interface fsgs_rsp_if;
	import fsgs_pkg::*;

	logic               valid;
	logic               ready;
	logic [CELL_W-1:0]  cell_value;
	logic [COUNT_W-1:0] particle_total;

	modport source (output valid, cell_value, particle_total, input ready);
	modport sink (input valid, cell_value, particle_total, output ready);
endinterface

// File: hw/rtl/falling_sand_grid_step_top.sv
// read: FETCH, LOAD; place: PLACE first; result shows as the block takes requests again
// clear: CLEAR over every cell, one memory write per cell, then FETCH and LOAD
// step: sweeps each cell above the bottom row; an empty cell takes SW_RD and SW_CHK,
// a blocked grain adds SW_DIAG, a straight fall SW_WR0 and SW_WR1, a diagonal move all
// three, on the single write port; one request at a time; a finished result waits
// in its own register; reset: async active low, then a clearing pass of all cells
module falling_sand_grid_step_top #(
	parameter int GRID_ROWS = fsgs_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLS = fsgs_pkg::GRID_COLS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	fsgs_req_if.sink                    req,
	fsgs_rsp_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fsgs_pkg::APB_AW-1:0] paddr,
	input  logic [fsgs_pkg::APB_DW-1:0] pwdata,
	output logic [fsgs_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import fsgs_pkg::*;

	localparam int CELLS = GRID_ROWS * GRID_COLS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = (GRID_COLS > 2) ? $clog2(GRID_COLS) : 1;
	localparam int BW    = 11;
	localparam logic [AW-1:0] COLS_A     = AW'(GRID_COLS);
	localparam logic [AW-1:0] SWEEP_ADDR = AW'(CELLS - GRID_COLS - 1);
	localparam logic [AW-1:0] LAST_ADDR  = AW'(CELLS - 1);
	localparam logic [CW-1:0] LAST_COL   = CW'(GRID_COLS - 1);

	state_t state_q, state_d;

	logic [CELL_W-1:0]  seed_q;
	logic [CELL_W-1:0]  lfsr_q;
	logic [CELL_W-1:0]  colour_q;
	logic [COUNT_W-1:0] count_q;

	logic               inside_q;
	logic [AW-1:0]      item_addr_q;
	logic [AW-1:0]      here_q;
	logic [CW-1:0]      col_q;
	logic [AW-1:0]      clr_q;
	logic [AW-1:0]      dest_q;
	logic [CELL_W-1:0]  val_q;
	logic               dir_left_q;

	logic               out_valid_q;
	logic [CELL_W-1:0]  cell_value_q;
	logic [COUNT_W-1:0] total_q;

	logic [CELL_W-1:0]  grid_mem [CELLS];
	logic [CELL_W-1:0]  rd_a_q, rd_b_q;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [CELL_W-1:0] wdata;
	logic [AW-1:0]     ra, rb;
	logic              capture;
	logic              slot_free;
	logic              cfg_wr;

	logic [AW-1:0] below_addr, left_addr, right_addr;
	logic          at_left, at_right, sweep_last;
	logic          below_free, left_free, right_free, first_free, second_free;
	logic [AW-1:0] first_addr, second_addr;
	logic          req_inside;

	assign below_addr = here_q + COLS_A;
	assign left_addr  = below_addr - AW'(1);
	assign at_left    = (col_q == '0);
	assign at_right   = (col_q == LAST_COL);
	// past the right edge the address is not used, keep it in range
	assign right_addr = at_right ? below_addr : below_addr + AW'(1);
	assign sweep_last = (here_q == '0);

	assign below_free  = (rd_b_q == '0);
	assign left_free   = !at_left && (rd_a_q == '0);
	assign right_free  = !at_right && (rd_b_q == '0);
	assign first_free  = dir_left_q ? left_free : right_free;
	assign second_free = dir_left_q ? right_free : left_free;
	assign first_addr  = dir_left_q ? left_addr : right_addr;
	assign second_addr = dir_left_q ? right_addr : left_addr;

	assign req_inside = (BW'(req.col) < BW'(GRID_COLS)) && (BW'(req.row) < BW'(GRID_ROWS));
	assign slot_free  = !out_valid_q || rsp.ready;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RNG_SEED);
	assign prdata = (paddr[2] == REG_RNG_SEED) ? APB_DW'(seed_q) : '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT_CLR: begin
				if (clr_q == LAST_ADDR) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req.valid) begin
					case (kind_t'(req.kind))
						KIND_PLACE: state_d = ST_PLACE;
						KIND_STEP:  state_d = ST_SW_RD;
						KIND_CLEAR: state_d = ST_CLEAR;
						default:    state_d = ST_FETCH;
					endcase
				end
			end
			ST_PLACE: state_d = ST_FETCH;
			ST_CLEAR: begin
				if (clr_q == LAST_ADDR) state_d = ST_FETCH;
			end
			ST_SW_RD: state_d = ST_SW_CHK;
			ST_SW_CHK: begin
				if (rd_a_q == '0) state_d = sweep_last ? ST_FETCH : ST_SW_RD;
				else if (below_free) state_d = ST_SW_WR0;
				else state_d = ST_SW_DIAG;
			end
			ST_SW_DIAG: begin
				if (first_free || second_free) state_d = ST_SW_WR0;
				else state_d = sweep_last ? ST_FETCH : ST_SW_RD;
			end
			ST_SW_WR0: state_d = ST_SW_WR1;
			ST_SW_WR1: state_d = sweep_last ? ST_FETCH : ST_SW_RD;
			ST_FETCH:  state_d = ST_LOAD;
			ST_LOAD: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory port and handshake controls
	always_comb begin
		we        = 1'b0;
		waddr     = here_q;
		wdata     = '0;
		ra        = here_q;
		rb        = below_addr;
		capture   = 1'b0;
		req.ready = 1'b0;
		case (state_q)
			ST_INIT_CLR, ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			ST_IDLE: req.ready = 1'b1;
			ST_PLACE: begin
				we    = inside_q;
				waddr = item_addr_q;
				wdata = colour_q;
			end
			ST_SW_CHK: begin
				ra = left_addr;
				rb = right_addr;
			end
			ST_SW_WR0: we = 1'b1;
			ST_SW_WR1: begin
				we    = 1'b1;
				waddr = dest_q;
				wdata = val_q;
			end
			ST_FETCH: ra = inside_q ? item_addr_q : '0;
			// keep the addressed cell on the read port while the result slot is busy
			ST_LOAD: begin
				ra      = inside_q ? item_addr_q : '0;
				capture = slot_free;
			end
			default: ;
		endcase
	end

	// grid memory, registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			grid_mem[waddr] <= wdata;
		end
		rd_a_q <= grid_mem[ra];
		rd_b_q <= grid_mem[rb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT_CLR;
			seed_q      <= SEED_RESET;
			lfsr_q      <= SEED_RESET;
			colour_q    <= CELL_W'(1);
			count_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				seed_q <= pwdata[CELL_W-1:0];
			end
			if (capture) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT_CLR: clr_q <= (clr_q == LAST_ADDR) ? '0 : clr_q + AW'(1);
				ST_CLEAR: begin
					clr_q   <= (clr_q == LAST_ADDR) ? '0 : clr_q + AW'(1);
					count_q <= '0;
					lfsr_q  <= (seed_q != '0) ? seed_q : CELL_W'(1);
				end
				ST_PLACE: begin
					if (inside_q) begin
						colour_q <= (colour_q == COLOUR_MAX) ? CELL_W'(1) : colour_q + CELL_W'(1);
						if (count_q != COUNT_MAX) count_q <= count_q + COUNT_W'(1);
					end
				end
				ST_SW_CHK: begin
					if (rd_a_q != '0) lfsr_q <= lfsr_next(lfsr_q);
				end
				default: ;
			endcase
		end
	end

	// request and sweep registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					inside_q    <= req_inside;
					item_addr_q <= AW'(req.row) * COLS_A + AW'(req.col);
					here_q      <= SWEEP_ADDR;
					col_q       <= LAST_COL;
				end
			end
			ST_SW_CHK: begin
				val_q      <= rd_a_q;
				dir_left_q <= lfsr_q[0];
				dest_q     <= below_addr;
				if (rd_a_q == '0 && !sweep_last) begin
					here_q <= here_q - AW'(1);
					col_q  <= at_left ? LAST_COL : col_q - CW'(1);
				end
			end
			ST_SW_DIAG: begin
				dest_q <= first_free ? first_addr : second_addr;
				if (!first_free && !second_free && !sweep_last) begin
					here_q <= here_q - AW'(1);
					col_q  <= at_left ? LAST_COL : col_q - CW'(1);
				end
			end
			ST_SW_WR1: begin
				if (!sweep_last) begin
					here_q <= here_q - AW'(1);
					col_q  <= at_left ? LAST_COL : col_q - CW'(1);
				end
			end
			default: ;
		endcase
		if (capture) begin
			cell_value_q <= inside_q ? rd_a_q : '0;
			total_q      <= count_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.cell_value     = cell_value_q;
	assign rsp.particle_total = total_q;

endmodule
